@@ design/assert_macros.svh @@
// Assertion helpers for the colour converter; both expect clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Consequent checked in the same cycle as the antecedent.
`define HSL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hsl2rgb: same-cycle check failed");

// Consequent checked in the cycle after the antecedent.
`define HSL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hsl2rgb: next-cycle check failed");

`endif

@@ design/hsl2rgb_pkg.sv @@
package hsl2rgb_pkg;

  localparam int FRAC_BITS = 24;

  // lightness and saturation in unsigned Q1.24, below 2.0
  localparam int LF_W    = FRAC_BITS + 1;
  localparam int T2P_W   = 2 * LF_W + 1;
  localparam int RECIP_W = FRAC_BITS + 10;
  localparam int HP_W    = 15 + RECIP_W;
  localparam int DH_W    = HP_W - 24;
  // signed hue position, and signed levels with headroom for out-of-range inputs
  localparam int T_W     = FRAC_BITS + 2;
  localparam int LVL_W   = FRAC_BITS + 6;
  localparam int M_W     = FRAC_BITS + 1;

  localparam int NSTAGE  = 7;

  localparam logic [RECIP_W-1:0] HUE_RECIP =
    RECIP_W'(((64'd1 << (FRAC_BITS + 24)) + 64'd23039) / 64'd23040);

  localparam logic signed [T_W-1:0] T_ONE        = T_W'(64'd1 << FRAC_BITS);
  localparam logic signed [T_W-1:0] T_THIRD      = T_W'(((64'd1 << FRAC_BITS) + 64'd1) / 64'd3);
  localparam logic signed [T_W-1:0] T_TWO_THIRDS = T_W'(((64'd2 << FRAC_BITS) + 64'd1) / 64'd3);
  localparam logic signed [T_W-1:0] T_ZERO       = '0;
  localparam logic signed [T_W-1:0] T_NEG_THIRD  = -T_THIRD;

  typedef logic [NSTAGE-1:0] stage_vec_t;

  typedef struct packed {
    logic [14:0] hue;
    logic [16:0] saturation;
    logic [16:0] lightness;
  } in_word_t;

  typedef struct packed {
    logic [7:0]  red;
    logic [7:0]  green;
    logic [7:0]  blue;
    logic [23:0] packed_color;
  } out_word_t;

  typedef struct packed {
    logic       black;
    logic       gray;
    logic [7:0] gray_val;
  } special_t;

  typedef struct packed {
    logic signed [LVL_W-1:0] t1;
    logic signed [LVL_W-1:0] t2;
    logic signed [LVL_W-1:0] diff;
  } levels_t;

endpackage

@@ design/hsl2rgb_front.sv @@
module hsl2rgb_front (
  input  logic                             clk,
  input  hsl2rgb_pkg::stage_vec_t          en,
  input  hsl2rgb_pkg::in_word_t            in_data,
  output logic [hsl2rgb_pkg::DH_W-1:0]     dh,
  output hsl2rgb_pkg::levels_t             lev,
  output hsl2rgb_pkg::special_t            spec
);

  localparam int F     = hsl2rgb_pkg::FRAC_BITS;
  localparam int LF_W  = hsl2rgb_pkg::LF_W;
  localparam int T2P_W = hsl2rgb_pkg::T2P_W;
  localparam int HP_W  = hsl2rgb_pkg::HP_W;
  localparam int DH_W  = hsl2rgb_pkg::DH_W;
  localparam int LVL_W = hsl2rgb_pkg::LVL_W;
  localparam int T2Q_W = T2P_W - F;

  // stage 0
  logic [HP_W-1:0]       hp_r, hp_nxt;
  logic [T2P_W-1:0]      t2p_r, t2p_nxt;
  logic                  low_r, low_nxt;
  logic [LF_W-1:0]       lf_r, lf_nxt;
  logic [LF_W-1:0]       sf_r, sf_nxt;
  hsl2rgb_pkg::special_t spec0_r, spec0_nxt;
  logic [LF_W:0]         mul_b;
  logic [24:0]           gsum;

  // stage 1
  logic [DH_W-1:0]         dh_r, dh_nxt;
  logic signed [LVL_W-1:0] t2_r, t2_nxt;
  logic [LF_W-1:0]         lf1_r;
  hsl2rgb_pkg::special_t   spec1_r;
  logic [HP_W-1:0]         hp_rnd;
  logic [T2Q_W-1:0]        t2q;

  // stage 2
  hsl2rgb_pkg::levels_t    lev_r, lev_nxt;
  hsl2rgb_pkg::special_t   spec2_r;

  always_comb begin
    lf_nxt  = LF_W'(in_data.lightness) << (F - 16);
    sf_nxt  = LF_W'(in_data.saturation) << (F - 16);
    low_nxt = in_data.lightness < 17'd32768;
    mul_b   = low_nxt ? (((LF_W + 1)'(1) << F) + (LF_W + 1)'(sf_nxt)) : (LF_W + 1)'(sf_nxt);
    t2p_nxt = T2P_W'(lf_nxt) * T2P_W'(mul_b);
    hp_nxt  = HP_W'(in_data.hue) * HP_W'(hsl2rgb_pkg::HUE_RECIP);

    gsum = (25'(in_data.lightness) << 8) - 25'(in_data.lightness) + 25'd32768;
    spec0_nxt.black    = in_data.lightness == '0;
    spec0_nxt.gray     = in_data.saturation == '0;
    spec0_nxt.gray_val = gsum[24] ? 8'hFF : gsum[23:16];
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      hp_r    <= hp_nxt;
      t2p_r   <= t2p_nxt;
      low_r   <= low_nxt;
      lf_r    <= lf_nxt;
      sf_r    <= sf_nxt;
      spec0_r <= spec0_nxt;
    end
  end

  // hue / 23040, rounded half up; second level from the truncated product
  always_comb begin
    hp_rnd = hp_r + HP_W'(64'd1 << 23);
    dh_nxt = hp_rnd[HP_W-1:24];
    t2q    = t2p_r[T2P_W-1:F];
    if (low_r) begin
      t2_nxt = LVL_W'(t2q);
    end else begin
      t2_nxt = LVL_W'(lf_r) + LVL_W'(sf_r) - LVL_W'(t2q);
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      dh_r    <= dh_nxt;
      t2_r    <= t2_nxt;
      lf1_r   <= lf_r;
      spec1_r <= spec0_r;
    end
  end

  always_comb begin
    lev_nxt.t2   = t2_r;
    lev_nxt.t1   = (LVL_W'(lf1_r) << 1) - t2_r;
    lev_nxt.diff = (t2_r - LVL_W'(lf1_r)) << 1;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      lev_r   <= lev_nxt;
      spec2_r <= spec1_r;
    end
  end

  assign dh   = dh_r;
  assign lev  = lev_r;
  assign spec = spec2_r;

endmodule

@@ design/hsl2rgb_chan.sv @@
module hsl2rgb_chan (
  input  logic                                 clk,
  input  hsl2rgb_pkg::stage_vec_t              en,
  input  logic [hsl2rgb_pkg::DH_W-1:0]         dh,
  input  logic signed [hsl2rgb_pkg::T_W-1:0]   hue_off,
  input  hsl2rgb_pkg::levels_t                 lev,
  output logic [7:0]                           chan_byte
);

  localparam int F     = hsl2rgb_pkg::FRAC_BITS;
  localparam int T_W   = hsl2rgb_pkg::T_W;
  localparam int LVL_W = hsl2rgb_pkg::LVL_W;
  localparam int M_W   = hsl2rgb_pkg::M_W;
  localparam int CW    = T_W + 2;
  localparam int PW    = LVL_W + M_W + 1;
  localparam int BW    = LVL_W + 8;
  localparam int VW    = BW - F;
  localparam logic [PW-1:0] TRUNC_BIAS = PW'((64'd1 << F) - 64'd1);

  // stage 2: wrapped hue position
  logic signed [T_W-1:0] t_raw, t_wrap, t_r, t_nxt;

  // stage 3: ramp factor and base level
  logic signed [CW-1:0]    t_w, t6, t2x, t3x, d3, m3, one_w, two_w;
  logic [M_W-1:0]          m_r, m_nxt;
  logic signed [LVL_W-1:0] base3_r, base3_nxt;
  logic signed [LVL_W-1:0] diff3_r;

  // stage 4: product
  logic signed [PW-1:0]    prod_r, prod_nxt;
  logic signed [LVL_W-1:0] base4_r;

  // stage 5: channel level
  logic signed [PW-1:0]    adj, q;
  logic signed [LVL_W-1:0] lvl_r, lvl_nxt;
  logic [BW-1:0]           bsum;
  logic [VW-1:0]           bval;

  // wrap once each way
  always_comb begin
    t_raw  = $signed({1'b0, dh}) + hue_off;
    t_wrap = (t_raw < 0) ? (t_raw + hsl2rgb_pkg::T_ONE) : t_raw;
    t_nxt  = (t_wrap > hsl2rgb_pkg::T_ONE) ? (t_wrap - hsl2rgb_pkg::T_ONE) : t_wrap;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      t_r <= t_nxt;
    end
  end

  // constant segments use a zero factor so every path shares one multiplier
  always_comb begin
    t_w   = CW'(t_r);
    t6    = (t_w <<< 2) + (t_w <<< 1);
    t2x   = t_w <<< 1;
    t3x   = (t_w <<< 1) + t_w;
    one_w = CW'(hsl2rgb_pkg::T_ONE);
    two_w = one_w <<< 1;
    d3    = CW'(hsl2rgb_pkg::T_TWO_THIRDS) - t_w;
    m3    = (d3 <<< 2) + (d3 <<< 1);
    if (t6 < one_w) begin
      m_nxt     = M_W'(t6);
      base3_nxt = lev.t1;
    end else if (t2x < one_w) begin
      m_nxt     = '0;
      base3_nxt = lev.t2;
    end else if (t3x < two_w) begin
      m_nxt     = M_W'(m3);
      base3_nxt = lev.t1;
    end else begin
      m_nxt     = '0;
      base3_nxt = lev.t1;
    end
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      m_r     <= m_nxt;
      base3_r <= base3_nxt;
      diff3_r <= lev.diff;
    end
  end

  always_comb begin
    prod_nxt = PW'(diff3_r) * PW'($signed({1'b0, m_r}));
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      prod_r  <= prod_nxt;
      base4_r <= base3_r;
    end
  end

  // truncate toward zero: bias negative products before the shift
  always_comb begin
    adj     = prod_r + (prod_r[PW-1] ? TRUNC_BIAS : '0);
    q       = adj >>> F;
    lvl_nxt = base4_r + LVL_W'(q);
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      lvl_r <= lvl_nxt;
    end
  end

  // scale to 0..255, round half up, clamp
  always_comb begin
    bsum = ({8'b0, lvl_r} << 8) - {8'b0, lvl_r} + BW'(64'd1 << (F - 1));
    bval = bsum[BW-1:F];
    if (lvl_r[LVL_W-1]) begin
      chan_byte = 8'd0;
    end else if (bval > VW'(255)) begin
      chan_byte = 8'hFF;
    end else begin
      chan_byte = bval[7:0];
    end
  end

endmodule

@@ design/hsl_to_rgb_converter.sv @@
// HSL to RGB colour converter, seven register stages.
// Each accepted word moves through stages 0 to 6 in order and is offered on out_data from stage 6.
// Throughput: one word per cycle; a stalled output holds only the stages behind it,
// and empty stages keep accepting until the pipeline is full.
// Reset (rst_n low, synchronous) empties every stage; data registers are not cleared.
`include "assert_macros.svh"

module hsl_to_rgb_converter (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  hsl2rgb_pkg::in_word_t    in_data,
  output logic                     out_valid,
  input  logic                     out_ready,
  output hsl2rgb_pkg::out_word_t   out_data
);

  localparam int LAST = hsl2rgb_pkg::NSTAGE - 1;

  hsl2rgb_pkg::stage_vec_t v_r, v_nxt, rdy;

  logic [hsl2rgb_pkg::DH_W-1:0] dh;
  hsl2rgb_pkg::levels_t         lev;
  hsl2rgb_pkg::special_t        spec2, spec3_r, spec4_r, spec5_r;
  logic [7:0]                   red_b, green_b, blue_b;
  hsl2rgb_pkg::out_word_t       out_r, out_nxt;

  // a stage may load when it is empty or its word moves on
  always_comb begin
    rdy[LAST] = !v_r[LAST] || out_ready;
    for (int k = LAST - 1; k >= 0; k--) begin
      rdy[k] = !v_r[k] || rdy[k+1];
    end
    v_nxt[0] = rdy[0] ? in_valid : v_r[0];
    for (int k = 1; k <= LAST; k++) begin
      v_nxt[k] = rdy[k] ? v_r[k-1] : v_r[k];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= v_nxt;
    end
  end

  hsl2rgb_front u_front (
    .clk     (clk),
    .en      (rdy),
    .in_data (in_data),
    .dh      (dh),
    .lev     (lev),
    .spec    (spec2)
  );

  hsl2rgb_chan u_red (
    .clk       (clk),
    .en        (rdy),
    .dh        (dh),
    .hue_off   (hsl2rgb_pkg::T_THIRD),
    .lev       (lev),
    .chan_byte (red_b)
  );

  hsl2rgb_chan u_green (
    .clk       (clk),
    .en        (rdy),
    .dh        (dh),
    .hue_off   (hsl2rgb_pkg::T_ZERO),
    .lev       (lev),
    .chan_byte (green_b)
  );

  hsl2rgb_chan u_blue (
    .clk       (clk),
    .en        (rdy),
    .dh        (dh),
    .hue_off   (hsl2rgb_pkg::T_NEG_THIRD),
    .lev       (lev),
    .chan_byte (blue_b)
  );

  // carry the black and gray flags alongside the channel stages
  always_ff @(posedge clk) begin
    if (rdy[3]) begin
      spec3_r <= spec2;
    end
    if (rdy[4]) begin
      spec4_r <= spec3_r;
    end
    if (rdy[5]) begin
      spec5_r <= spec4_r;
    end
  end

  always_comb begin
    if (spec5_r.black) begin
      out_nxt.red   = 8'd0;
      out_nxt.green = 8'd0;
      out_nxt.blue  = 8'd0;
    end else if (spec5_r.gray) begin
      out_nxt.red   = spec5_r.gray_val;
      out_nxt.green = spec5_r.gray_val;
      out_nxt.blue  = spec5_r.gray_val;
    end else begin
      out_nxt.red   = red_b;
      out_nxt.green = green_b;
      out_nxt.blue  = blue_b;
    end
    out_nxt.packed_color = {out_nxt.blue, out_nxt.green, out_nxt.red};
  end

  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      out_r <= out_nxt;
    end
  end

  assign in_ready  = rdy[0];
  assign out_valid = v_r[LAST];
  assign out_data  = out_r;

  `HSL_ASSERT_NOW(a_empty_output_takes_input, !v_r[LAST], in_ready)
  `HSL_ASSERT_NEXT(a_last_stage_drains, v_r[LAST-1] && rdy[LAST], out_valid)
  `HSL_ASSERT_NEXT(a_blocked_word_kept, v_r[LAST-1] && !rdy[LAST], v_r[LAST-1])

endmodule
